@@ design/macs_pkg.sv @@
// shared constants, types and helpers of the moving average crossover block
package macs_pkg;

    // window geometry and field widths
    localparam int WINDOW  = 64;
    localparam int PTR_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SYM_W   = 16;
    localparam int PRICE_W = 32;
    localparam int PER_W   = 7;
    localparam int SUM_W   = PRICE_W + PTR_W;
    localparam int PROD_W  = SUM_W + CNT_W;
    localparam int TRY_W   = PTR_W + 1;
    localparam int DIV_W   = $clog2(SUM_W);

    // stream and configuration port widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 72;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_SHORT_PERIODS  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_LONG_PERIODS   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_WATCHED_SYMBOL = 2'd2;

    // configuration reset values
    localparam logic [PER_W-1:0] SHORT_RESET = 7'd2;
    localparam logic [PER_W-1:0] LONG_RESET  = 7'd3;
    localparam logic [SYM_W-1:0] WATCH_RESET = 16'd0;

    // trading signal codes
    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_GATE,
        ST_MUL_S,
        ST_MUL_L,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic gate;
        logic mul_en;
        logic mul_sel;
        logic cmp;
        logic div_step;
        logic load_out;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_issue;
        logic div_last;
        logic out_busy;
    } stat_t;

    // period of zero counts as one, above the window as the window
    function automatic logic [CNT_W-1:0] clamp_period(input logic [PER_W-1:0] p);
        logic [CNT_W-1:0] r;
        if (p == '0) begin
            r = CNT_W'(1);
        end else if (int'(p) > WINDOW) begin
            r = CNT_W'(WINDOW);
        end else begin
            r = CNT_W'(p);
        end
        return r;
    endfunction

endpackage

@@ design/macs_ram.sv @@
// generic single write port ram with registered read
module macs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/macs_ctrl.sv @@
// sequencing state machine of the moving average crossover block
module macs_ctrl
    import macs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (stat.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_GATE;
            ST_GATE:  state_next = ST_MUL_S;
            ST_MUL_S: state_next = ST_MUL_L;
            ST_MUL_L: state_next = ST_CMP;
            ST_CMP:   state_next = ST_DIV;
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs, no request is taken while reset is held
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = aresetn;
                cmd.start = s_tvalid && aresetn;
            end
            ST_READ:  cmd.issue = 1'b1;
            ST_DRAIN: cmd = '0;
            ST_GATE:  cmd.gate = 1'b1;
            ST_MUL_S: cmd.mul_en = 1'b1;
            ST_MUL_L: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 1'b1;
            end
            ST_CMP:   cmd.cmp = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_DONE:  cmd.load_out = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

@@ design/macs_dp.sv @@
// datapath: configuration, window pointers, sums, cross multiply and dividers
module macs_dp
    import macs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    input  cmd_t                cmd,
    output stat_t               stat
);

    // configuration registers
    logic [PER_W-1:0] short_cfg_reg;
    logic [PER_W-1:0] long_cfg_reg;
    logic [SYM_W-1:0] watch_reg;

    // window bookkeeping
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             acc_vld_reg, acc_vld_next;
    logic [CNT_W-1:0] acc_k_reg, acc_k_next;

    // arithmetic
    logic [SUM_W-1:0]  short_acc_reg, short_acc_next;
    logic [SUM_W-1:0]  long_acc_reg, long_acc_next;
    logic [PROD_W-1:0] lhs_reg, lhs_next;
    logic [PROD_W-1:0] rhs_reg, rhs_next;
    signal_t           signal_reg, signal_next;
    logic [PTR_W-1:0]  rem_reg [2];
    logic [PTR_W-1:0]  rem_next [2];
    logic [SUM_W-1:0]  quo_reg [2];
    logic [SUM_W-1:0]  quo_next [2];
    logic [DIV_W-1:0]  div_cnt_reg, div_cnt_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [1:0]         m_signal_reg;
    logic [PRICE_W-1:0] m_short_reg;
    logic [PRICE_W-1:0] m_long_reg;

    logic [SYM_W-1:0]   in_symbol;
    logic [PRICE_W-1:0] in_price;
    logic               watched;
    logic [CNT_W-1:0]   sp;
    logic [CNT_W-1:0]   lp;
    logic [CNT_W-1:0]   n_reads;
    logic [PRICE_W-1:0] ram_rdata;
    logic [SUM_W-1:0]   mul_a;
    logic [CNT_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod;
    logic [CNT_W-1:0]   div_d [2];
    logic [TRY_W-1:0]   div_try [2];

    assign in_symbol = s_tdata[SYM_W-1:0];
    assign in_price  = s_tdata[SYM_W+PRICE_W-1:SYM_W];
    assign watched   = (in_symbol == watch_reg);
    assign sp        = clamp_period(short_cfg_reg);
    assign lp        = clamp_period(long_cfg_reg);
    assign n_reads   = (sp > lp) ? sp : lp;
    assign div_d[0]  = sp;
    assign div_d[1]  = lp;

    // price window storage
    macs_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (cmd.start && watched),
        .waddr (wp_reg),
        .wdata (in_price),
        .re    (cmd.issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // shared multiplier, short sum by long period then long sum by short period
    assign mul_a = cmd.mul_sel ? long_acc_reg : short_acc_reg;
    assign mul_b = cmd.mul_sel ? sp : lp;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    // status
    always_comb begin
        stat.last_issue = (k_reg == n_reads - CNT_W'(1));
        stat.div_last   = (div_cnt_reg == DIV_W'(SUM_W - 1));
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

    // next values of the control state
    always_comb begin
        wp_next       = wp_reg;
        seen_next     = seen_reg;
        rd_ptr_next   = rd_ptr_reg;
        k_next        = k_reg;
        acc_vld_next  = cmd.issue;
        acc_k_next    = k_reg;
        m_tvalid_next = m_tvalid_reg;
        div_cnt_next  = div_cnt_reg;

        // new request: store a watched price, point at the newest entry
        if (cmd.start) begin
            k_next = '0;
            if (watched) begin
                rd_ptr_next = wp_reg;
                wp_next     = (wp_reg == PTR_W'(WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);
                if (seen_reg != CNT_W'(WINDOW)) begin
                    seen_next = seen_reg + CNT_W'(1);
                end
            end else begin
                rd_ptr_next = (wp_reg == '0) ? PTR_W'(WINDOW - 1) : wp_reg - PTR_W'(1);
            end
        end

        // walk backward through the window
        if (cmd.issue) begin
            k_next      = k_reg + CNT_W'(1);
            rd_ptr_next = (rd_ptr_reg == '0) ? PTR_W'(WINDOW - 1) : rd_ptr_reg - PTR_W'(1);
        end

        if (cmd.cmp) begin
            div_cnt_next = '0;
        end else if (cmd.div_step) begin
            div_cnt_next = div_cnt_reg + DIV_W'(1);
        end

        // output handshake
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // next values of the arithmetic registers
    always_comb begin
        short_acc_next = short_acc_reg;
        long_acc_next  = long_acc_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        signal_next    = signal_reg;
        div_try        = '{default: '0};
        for (int i = 0; i < 2; i++) begin
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
        end

        // accumulate the price read in the previous cycle
        if (cmd.start) begin
            short_acc_next = '0;
            long_acc_next  = '0;
        end else if (acc_vld_reg) begin
            if (acc_k_reg < sp) begin
                short_acc_next = short_acc_reg + SUM_W'(ram_rdata);
            end
            if (acc_k_reg < lp) begin
                long_acc_next = long_acc_reg + SUM_W'(ram_rdata);
            end
        end

        // an average with too few stored prices counts as zero
        if (cmd.gate) begin
            if (seen_reg < sp) begin
                short_acc_next = '0;
            end
            if (seen_reg < lp) begin
                long_acc_next = '0;
            end
        end

        if (cmd.mul_en) begin
            if (cmd.mul_sel) begin
                rhs_next = prod;
            end else begin
                lhs_next = prod;
            end
        end

        // compare the cross products and load both dividers
        if (cmd.cmp) begin
            if (lhs_reg > rhs_reg) begin
                signal_next = SIG_BUY;
            end else if (lhs_reg < rhs_reg) begin
                signal_next = SIG_SELL;
            end else begin
                signal_next = SIG_HOLD;
            end
            rem_next[0] = '0;
            rem_next[1] = '0;
            quo_next[0] = short_acc_reg;
            quo_next[1] = long_acc_reg;
        end

        // one restoring division step per lane
        if (cmd.div_step) begin
            for (int i = 0; i < 2; i++) begin
                div_try[i] = {rem_reg[i], quo_reg[i][SUM_W-1]};
                if (div_try[i] >= TRY_W'(div_d[i])) begin
                    rem_next[i] = PTR_W'(div_try[i] - TRY_W'(div_d[i]));
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = div_try[i][PTR_W-1:0];
                    quo_next[i] = {quo_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_cfg_reg <= SHORT_RESET;
            long_cfg_reg  <= LONG_RESET;
            watch_reg     <= WATCH_RESET;
            wp_reg        <= '0;
            seen_reg      <= '0;
            acc_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_SHORT_PERIODS:  short_cfg_reg <= cfg_wdata[PER_W-1:0];
                    REG_LONG_PERIODS:   long_cfg_reg  <= cfg_wdata[PER_W-1:0];
                    REG_WATCHED_SYMBOL: watch_reg     <= cfg_wdata[SYM_W-1:0];
                    default:            watch_reg     <= watch_reg;
                endcase
            end
            wp_reg       <= wp_next;
            seen_reg     <= seen_next;
            acc_vld_reg  <= acc_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        rd_ptr_reg    <= rd_ptr_next;
        k_reg         <= k_next;
        acc_k_reg     <= acc_k_next;
        short_acc_reg <= short_acc_next;
        long_acc_reg  <= long_acc_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        signal_reg    <= signal_next;
        div_cnt_reg   <= div_cnt_next;
        for (int i = 0; i < 2; i++) begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
        end
        if (cmd.load_out) begin
            m_signal_reg <= signal_reg;
            m_short_reg  <= quo_reg[0][PRICE_W-1:0];
            m_long_reg   <= quo_reg[1][PRICE_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W - 2 - 2 * PRICE_W)'(0), m_long_reg, m_short_reg, m_signal_reg};

endmodule

@@ design/moving_average_crossover_signal.sv @@
// Moving average crossover: each request (one market tick) returns one result with the
// short and long simple moving averages of the watched symbol and a buy, sell or hold
// signal. A tick whose symbol id matches the watched symbol is stored in a 64 entry
// price window; others leave the window untouched but still get a result. From acceptance
// to a loaded result, a request makes one window read per cycle from the single read port
// of the price memory, uses the shared multiplier for the two cross products, and runs
// bit-serial division by the two periods, both divisions side by side. The next request
// can be taken in the cycle after the result is loaded. A new request is taken while the
// previous result still waits in the output register; its own result is then held back
// until that register is free. Configuration must be written only while idle; the user
// is bound by this, the block itself does not enforce it.
module moving_average_crossover_signal
    import macs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_wdata,
    // tick input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // symbol_id[15:0], price[47:16]
    // result output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // signal[1:0], short_avg[33:2], long_avg[65:34]
);

    cmd_t  cmd;
    stat_t stat;

    // sequencing
    macs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and storage
    macs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
